// File: sv/fixed_point_alu_nr_divide_assert.svh
// assertion helpers for the fixed-point alu, clocked on clk_i and held off during reset
`ifndef FIXED_POINT_ALU_NR_DIVIDE_ASSERT_SVH
`define FIXED_POINT_ALU_NR_DIVIDE_ASSERT_SVH

// plain property check
`define FPNR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies a result in the next cycle
`define FPNR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fpnr_pkg.sv
`default_nettype none

package fpnr_pkg;

  localparam int IntWidth    = 18;
  localparam int FracWidth   = 18;
  localparam int Word        = IntWidth + FracWidth;
  localparam int SeedEntries = 128;
  localparam int SeedBits    = $clog2(SeedEntries);
  localparam int MsbBits     = $clog2(Word);
  localparam int ShBits      = MsbBits + 1;

  // numerator of the reciprocal seed table
  localparam logic [63:0] SeedNumer = 64'(SeedEntries) << FracWidth;

  // stream widths, padded to whole bytes
  localparam int InDataBits  = ((2 * Word + 7) / 8) * 8;
  localparam int OutDataBits = ((Word + 7) / 8) * 8;

  // pipeline layout
  localparam int FrontStages = 4;
  localparam int NrStages    = 5;
  localparam int MulStages   = 2;
  localparam int StgNr1      = FrontStages;
  localparam int StgNr2      = StgNr1 + NrStages;
  localparam int StgScale    = StgNr2 + NrStages;
  localparam int StgSel      = StgScale + 1;
  localparam int StgMul      = StgSel + 1;
  localparam int StgOut      = StgMul + MulStages;
  localparam int Stages      = StgOut + 1;

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  // per-item information that rides along the pipeline
  typedef struct packed {
    cmd_e                     cmd;
    logic [Word-1:0]          opa;
    logic [Word-1:0]          opb;
    logic [Word-1:0]          sum;
    logic                     neg;
    logic                     zero;
    logic signed [ShBits-1:0] shamt;
    logic [Word-1:0]          norm;
  } side_t;

endpackage

`default_nettype wire

// File: sv/fpnr_mul.sv
`default_nettype none

// two-stage fixed-point multiply: (a * b) >>> frac, wrapped to the word
module fpnr_mul (
  input  wire logic                        clk_i,
  input  wire logic [1:0]                  en_i,
  input  wire logic [fpnr_pkg::Word-1:0]   a_i,
  input  wire logic [fpnr_pkg::Word-1:0]   b_i,
  output logic      [fpnr_pkg::Word-1:0]   p_o
);

  logic signed [fpnr_pkg::Word+fpnr_pkg::FracWidth:0]  prod_lo;
  logic signed [fpnr_pkg::Word+fpnr_pkg::IntWidth-1:0] prod_hi;
  logic [fpnr_pkg::Word-1:0] lo_q, lo_d, hi_q, hi_d, p_q, p_d;

  // split b at the binary point so the shift folds into the final add
  assign prod_lo = $signed(a_i) * $signed({1'b0, b_i[fpnr_pkg::FracWidth-1:0]});
  assign prod_hi = $signed(a_i) * $signed(b_i[fpnr_pkg::Word-1:fpnr_pkg::FracWidth]);

  assign lo_d = prod_lo[fpnr_pkg::Word+fpnr_pkg::FracWidth-1:fpnr_pkg::FracWidth];
  assign hi_d = prod_hi[fpnr_pkg::Word-1:0];
  assign p_d  = hi_q + lo_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (en_i[1]) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: sv/fpnr_front.sv
`default_nettype none

// divisor magnitude, leading-one search, normalize and reciprocal seed
module fpnr_front (
  input  wire logic                                    clk_i,
  input  wire logic [fpnr_pkg::FrontStages-1:0]        en_i,
  input  wire fpnr_pkg::cmd_e                          cmd_i,
  input  wire logic [fpnr_pkg::Word-1:0]               opa_i,
  input  wire logic [fpnr_pkg::Word-1:0]               opb_i,
  output fpnr_pkg::side_t                              side_o,
  output logic      [fpnr_pkg::Word-1:0]               x_o
);

  fpnr_pkg::side_t side0_q, side0_d, side1_q, side1_d, side2_q, side2_d, side3_q;
  logic [fpnr_pkg::Word-1:0]     mag0_q, mag0_d, mag1_q;
  logic [fpnr_pkg::MsbBits-1:0]  msb1_q, msb1_d;
  logic [fpnr_pkg::Word-1:0]     just;
  logic [fpnr_pkg::SeedBits-1:0] seed_idx;
  logic [fpnr_pkg::Word-1:0]     x3_q;
  logic [fpnr_pkg::Word-1:0]     seed_rom [fpnr_pkg::SeedEntries];

  // seed table: floor(2^frac * entries / (entries + i))
  for (genvar g = 0; g < fpnr_pkg::SeedEntries; g++) begin : g_rom
    localparam logic [63:0] Quot = fpnr_pkg::SeedNumer / 64'(fpnr_pkg::SeedEntries + g);
    assign seed_rom[g] = fpnr_pkg::Word'(Quot);
  end

  // stage 0: add/sub result and divisor magnitude
  always_comb begin
    side0_d      = '0;
    side0_d.cmd  = cmd_i;
    side0_d.opa  = opa_i;
    side0_d.opb  = opb_i;
    side0_d.sum  = (cmd_i == fpnr_pkg::CmdSub) ? opa_i - opb_i : opa_i + opb_i;
    side0_d.neg  = opb_i[fpnr_pkg::Word-1];
    mag0_d       = side0_d.neg ? '0 - opb_i : opb_i;
  end

  // stage 1: leading one of the magnitude
  always_comb begin
    msb1_d = '0;
    for (int i = 0; i < fpnr_pkg::Word; i++) begin
      if (mag0_q[i]) begin
        msb1_d = fpnr_pkg::MsbBits'(i);
      end
    end
    side1_d      = side0_q;
    side1_d.zero = (mag0_q == '0);
  end

  // stage 2: left-justify, then a fixed shift puts the leading one at the binary point
  always_comb begin
    just          = mag1_q << (fpnr_pkg::MsbBits'(fpnr_pkg::Word - 1) - msb1_q);
    side2_d       = side1_q;
    side2_d.norm  = fpnr_pkg::Word'(just >> (fpnr_pkg::IntWidth - 1));
    side2_d.shamt = side1_q.zero ? '0 :
                    $signed(fpnr_pkg::ShBits'(fpnr_pkg::FracWidth)) - $signed({1'b0, msb1_q});
  end

  // stage 3: seed from the top fraction bits
  assign seed_idx = side2_q.norm[fpnr_pkg::FracWidth-1 -: fpnr_pkg::SeedBits];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side0_q <= side0_d;
      mag0_q  <= mag0_d;
    end
    if (en_i[1]) begin
      side1_q <= side1_d;
      mag1_q  <= mag0_q;
      msb1_q  <= msb1_d;
    end
    if (en_i[2]) begin
      side2_q <= side2_d;
    end
    if (en_i[3]) begin
      side3_q <= side2_q;
      x3_q    <= seed_rom[seed_idx];
    end
  end

  assign side_o = side3_q;
  assign x_o    = x3_q;

endmodule

`default_nettype wire

// File: sv/fpnr_nr.sv
`default_nettype none

// one newton-raphson step x' = x * (2 - d * x) over five stages
module fpnr_nr (
  input  wire logic                              clk_i,
  input  wire logic [fpnr_pkg::NrStages-1:0]     en_i,
  input  wire logic [fpnr_pkg::Word-1:0]         norm_i,
  input  wire logic [fpnr_pkg::Word-1:0]         x_i,
  output logic      [fpnr_pkg::Word-1:0]         x_o
);

  localparam logic [fpnr_pkg::Word-1:0] Two = fpnr_pkg::Word'(2) << fpnr_pkg::FracWidth;

  logic [fpnr_pkg::Word-1:0] dx;
  logic [fpnr_pkg::Word-1:0] x0_q, x1_q, x2_q, t_q, t_d;

  fpnr_mul u_mul_dx (
    .clk_i (clk_i),
    .en_i  (en_i[1:0]),
    .a_i   (norm_i),
    .b_i   (x_i),
    .p_o   (dx)
  );

  assign t_d = Two - dx;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x0_q <= x_i;
    end
    if (en_i[1]) begin
      x1_q <= x0_q;
    end
    if (en_i[2]) begin
      x2_q <= x1_q;
      t_q  <= t_d;
    end
  end

  fpnr_mul u_mul_xt (
    .clk_i (clk_i),
    .en_i  (en_i[4:3]),
    .a_i   (x2_q),
    .b_i   (t_q),
    .p_o   (x_o)
  );

endmodule

`default_nettype wire

// File: sv/fixed_point_alu_nr_divide.sv
// Signed Q18.18 fixed-point ALU: add, subtract, multiply and reciprocal divide.
// Input words arrive on the s_axis channel: the command in tuser, both operands
// in tdata. Each word yields exactly one result word on the m_axis channel,
// carrying the wrapped result in tdata and a divide-by-zero flag in tuser.
// Every command runs through the same 19-stage pipeline, so results leave in
// order. Throughput is one word per cycle while m_axis_tready stays high; the
// depth is set by the divide path: leading-one search, normalize, seed table,
// two newton-raphson steps of two two-stage multipliers each, rescale, sign
// fix and the final multiply.
// When the receiver holds m_axis_tready low, the output word stays put and
// empty stages further up still fill, so s_axis_tready only drops once every
// stage holds a word. Reset empties the pipeline; no words are in flight and
// no results are produced until new input arrives.
`default_nettype none

`include "fixed_point_alu_nr_divide_assert.svh"

module fixed_point_alu_nr_divide (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // operand_a [35:0], operand_b [71:36]
  input  wire logic [fpnr_pkg::InDataBits-1:0]       s_axis_tdata,
  // command [1:0]
  input  wire logic [1:0]                            s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // result_value [35:0], zero pad above
  output logic      [fpnr_pkg::OutDataBits-1:0]      m_axis_tdata,
  // zero_divisor [0]
  output logic                                       m_axis_tuser
);

  logic [fpnr_pkg::Stages-1:0] valid_q, valid_d, en;

  fpnr_pkg::side_t           front_side;
  logic [fpnr_pkg::Word-1:0] x_seed, x_nr1, x_nr2, prod;
  fpnr_pkg::side_t           side_q [fpnr_pkg::StgNr1:fpnr_pkg::StgOut-1];

  logic [fpnr_pkg::ShBits-1:0]      sh_mag;
  logic signed [fpnr_pkg::Word-1:0] x_asr;
  logic [fpnr_pkg::Word-1:0]        scaled_q, scaled_d, oper_q, oper_d, recip;
  logic [fpnr_pkg::Word-1:0]        result_q, result_d;
  logic                             zdiv_q, zdiv_d;

  // a stage loads when the receiver is ready or it or any stage below it toward the output has room
  for (genvar g = 0; g < fpnr_pkg::Stages; g++) begin : g_en
    assign en[g] = m_axis_tready | ~(&valid_q[fpnr_pkg::Stages-1:g]);
  end

  assign valid_d = {valid_q[fpnr_pkg::Stages-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < fpnr_pkg::Stages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[fpnr_pkg::StgOut];

  fpnr_front u_front (
    .clk_i  (clk_i),
    .en_i   (en[fpnr_pkg::FrontStages-1:0]),
    .cmd_i  (fpnr_pkg::cmd_e'(s_axis_tuser)),
    .opa_i  (s_axis_tdata[fpnr_pkg::Word-1:0]),
    .opb_i  (s_axis_tdata[2*fpnr_pkg::Word-1:fpnr_pkg::Word]),
    .side_o (front_side),
    .x_o    (x_seed)
  );

  // side information follows the word down the pipe
  always_ff @(posedge clk_i) begin
    if (en[fpnr_pkg::StgNr1]) begin
      side_q[fpnr_pkg::StgNr1] <= front_side;
    end
  end

  for (genvar g = fpnr_pkg::StgNr1 + 1; g < fpnr_pkg::StgOut; g++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        side_q[g] <= side_q[g-1];
      end
    end
  end

  fpnr_nr u_nr1 (
    .clk_i  (clk_i),
    .en_i   (en[fpnr_pkg::StgNr1 +: fpnr_pkg::NrStages]),
    .norm_i (front_side.norm),
    .x_i    (x_seed),
    .x_o    (x_nr1)
  );

  fpnr_nr u_nr2 (
    .clk_i  (clk_i),
    .en_i   (en[fpnr_pkg::StgNr2 +: fpnr_pkg::NrStages]),
    .norm_i (side_q[fpnr_pkg::StgNr2-1].norm),
    .x_i    (x_nr1),
    .x_o    (x_nr2)
  );

  // undo the normalization: left shift with wrap or arithmetic right shift
  always_comb begin
    sh_mag = side_q[fpnr_pkg::StgScale-1].shamt[fpnr_pkg::ShBits-1] ?
             fpnr_pkg::ShBits'(-side_q[fpnr_pkg::StgScale-1].shamt) :
             fpnr_pkg::ShBits'(side_q[fpnr_pkg::StgScale-1].shamt);
    x_asr  = $signed(x_nr2) >>> sh_mag;
    if (side_q[fpnr_pkg::StgScale-1].shamt[fpnr_pkg::ShBits-1]) begin
      scaled_d = x_asr;
    end else begin
      scaled_d = x_nr2 << sh_mag;
    end
  end

  // sign fix, and pick the right-hand operand of the shared multiplier
  always_comb begin
    recip = side_q[fpnr_pkg::StgSel-1].neg ? '0 - scaled_q : scaled_q;
    if (side_q[fpnr_pkg::StgSel-1].cmd == fpnr_pkg::CmdDiv) begin
      oper_d = recip;
    end else begin
      oper_d = side_q[fpnr_pkg::StgSel-1].opb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[fpnr_pkg::StgScale]) begin
      scaled_q <= scaled_d;
    end
    if (en[fpnr_pkg::StgSel]) begin
      oper_q <= oper_d;
    end
  end

  fpnr_mul u_mul_out (
    .clk_i (clk_i),
    .en_i  (en[fpnr_pkg::StgMul +: fpnr_pkg::MulStages]),
    .a_i   (side_q[fpnr_pkg::StgMul-1].opa),
    .b_i   (oper_q),
    .p_o   (prod)
  );

  always_comb begin
    unique case (side_q[fpnr_pkg::StgOut-1].cmd)
      fpnr_pkg::CmdAdd, fpnr_pkg::CmdSub: result_d = side_q[fpnr_pkg::StgOut-1].sum;
      default:                            result_d = prod;
    endcase
    zdiv_d = (side_q[fpnr_pkg::StgOut-1].cmd == fpnr_pkg::CmdDiv) &&
             side_q[fpnr_pkg::StgOut-1].zero;
  end

  always_ff @(posedge clk_i) begin
    if (en[fpnr_pkg::StgOut]) begin
      result_q <= result_d;
      zdiv_q   <= zdiv_d;
    end
  end

  assign m_axis_tdata = fpnr_pkg::OutDataBits'(result_q);
  assign m_axis_tuser = zdiv_q;

  // input is refused only when every stage holds a word
  `FPNR_ASSERT(a_stall_full, s_axis_tready || (&valid_q), "input refused with room in pipe")
  // an accepted word lands in the first stage
  `FPNR_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, valid_q[0],
                    "accepted word lost at entry")
  // a word leaving the last compute stage reaches the output register
  `FPNR_ASSERT_NEXT(a_out_lands, valid_q[fpnr_pkg::StgOut-1] && en[fpnr_pkg::StgOut],
                    m_axis_tvalid, "word lost before output")
  // the zero flag only comes with a divide
  `FPNR_ASSERT_NEXT(a_zdiv_cmd,
                    en[fpnr_pkg::StgOut] &&
                    (side_q[fpnr_pkg::StgOut-1].cmd != fpnr_pkg::CmdDiv),
                    !zdiv_q, "zero flag on a non-divide")

endmodule

`default_nettype wire
